FILE: rtl/core/tra_pkg.sv
package tra_pkg;

	// Fixed shape of the register file and of the instruction fields.
	localparam int unsigned NUM_REGS       = 8;
	localparam int unsigned REG_IDX_W      = 3;
	localparam int unsigned OP_W           = 4;
	localparam int unsigned IMM_W          = 32;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// Operation codes. Codes above OP_MOV behave as a no-op.
	typedef enum logic [OP_W-1:0] {
		OP_NOP = 4'd0,
		OP_ADD = 4'd1,
		OP_AND = 4'd2,
		OP_OR  = 4'd3,
		OP_SUB = 4'd4,
		OP_XOR = 4'd5,
		OP_LSR = 4'd6,
		OP_LSL = 4'd7,
		OP_ASR = 4'd8,
		OP_MOV = 4'd9
	} op_t;

	// One decoded instruction as held in the input stage.
	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [REG_IDX_W-1:0] dest_reg;
		logic [REG_IDX_W-1:0] src_a;
		logic [REG_IDX_W-1:0] src_b;
		logic [IMM_W-1:0]     imm;
	} instr_t;

	// Write enables produced by the ALU for the register file.
	typedef struct packed {
		logic dest_en;
		logic src_en;
	} wr_t;

endpackage

FILE: rtl/core/tra_instr_if.sv
interface tra_instr_if;
	logic                           valid;
	logic                           ready;
	logic [tra_pkg::OP_W-1:0]       op;
	logic [tra_pkg::REG_IDX_W-1:0]  dest_reg;
	logic [tra_pkg::REG_IDX_W-1:0]  src_a;
	logic [tra_pkg::REG_IDX_W-1:0]  src_b;
	logic [tra_pkg::IMM_W-1:0]      imm;

	modport source (output valid, output op, output dest_reg, output src_a, output src_b,
		output imm, input ready);
	modport sink (input valid, input op, input dest_reg, input src_a, input src_b,
		input imm, output ready);
endinterface

FILE: rtl/core/tra_regs_if.sv
interface tra_regs_if #(
	parameter int unsigned DATA_WIDTH = tra_pkg::DATA_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] reg0_val;
	logic [DATA_WIDTH-1:0] reg1_val;
	logic [DATA_WIDTH-1:0] reg2_val;
	logic [DATA_WIDTH-1:0] reg3_val;
	logic [DATA_WIDTH-1:0] reg4_val;
	logic [DATA_WIDTH-1:0] reg5_val;
	logic [DATA_WIDTH-1:0] reg6_val;
	logic [DATA_WIDTH-1:0] reg7_val;

	modport source (output valid, output reg0_val, output reg1_val, output reg2_val,
		output reg3_val, output reg4_val, output reg5_val, output reg6_val,
		output reg7_val, input ready);
	modport sink (input valid, input reg0_val, input reg1_val, input reg2_val,
		input reg3_val, input reg4_val, input reg5_val, input reg6_val,
		input reg7_val, output ready);
endinterface

FILE: rtl/core/tra_alu.sv
module tra_alu #(
	parameter int unsigned DATA_WIDTH = tra_pkg::DATA_WIDTH_DEF
) (
	input  tra_pkg::instr_t        instr,
	input  logic [DATA_WIDTH-1:0]  a,
	input  logic [DATA_WIDTH-1:0]  b,
	output logic [DATA_WIDTH-1:0]  value,
	output tra_pkg::wr_t           wr
);
	import tra_pkg::*;

	localparam int unsigned SH_W = $clog2(DATA_WIDTH);

	logic                  big_shift;
	logic [SH_W-1:0]       sh_amt;
	logic [DATA_WIDTH-1:0] sign_fill;

	// Shift amounts at or above the data width saturate.
	assign big_shift = instr.imm >= IMM_W'(DATA_WIDTH);
	assign sh_amt    = instr.imm[SH_W-1:0];
	assign sign_fill = {DATA_WIDTH{a[DATA_WIDTH-1]}};

	// Operation select and write enables.
	always_comb begin
		value      = '0;
		wr.dest_en = 1'b1;
		wr.src_en  = 1'b0;
		case (instr.op)
			OP_ADD: value = a + b;
			OP_AND: value = a & b;
			OP_OR:  value = a | b;
			OP_SUB: value = a - b;
			OP_XOR: value = a ^ b;
			OP_LSR: value = big_shift ? '0 : (a >> sh_amt);
			OP_LSL: value = big_shift ? '0 : (a << sh_amt);
			OP_ASR: begin
				// The shifted value also lands back in the source register.
				value     = big_shift ? sign_fill : DATA_WIDTH'($signed(a) >>> sh_amt);
				wr.src_en = 1'b1;
			end
			OP_MOV: value = DATA_WIDTH'(instr.imm);
			default: wr.dest_en = 1'b0;
		endcase
	end

endmodule

FILE: rtl/core/toy_register_alu_executor.sv
// Register-file execute unit with eight registers, all cleared at reset.
// Input channel instr carries one decoded instruction per request: op,
// dest_reg, src_a, src_b and imm. Output channel result carries one request
// per instruction holding all eight register values after that instruction.
// Both channels use valid/ready; a request moves when both are high.
// An accepted instruction is registered in the input register, then executed
// into the register file, which is registered together with the result valid flag.
// Throughput: one instruction per cycle while the receiver keeps taking results,
// set by the read-modify-write of the register file that follows the input register.
// The register file itself serves as the result register, so back-to-back
// instructions see each other's writes with no bubble.
// When the receiver stalls, the pending result holds, one more instruction
// is taken into the input register, and then instr.ready drops until the
// result is taken.
// Reset clears all registers and drops both valid flags.
module toy_register_alu_executor #(
	parameter int unsigned DATA_WIDTH = tra_pkg::DATA_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tra_instr_if.sink instr,
	tra_regs_if.source result
);
	import tra_pkg::*;

	instr_t                                 instr_s1;
	logic                                   valid_s1;
	logic                                   out_valid_q;
	logic [NUM_REGS-1:0][DATA_WIDTH-1:0]    regs_q;
	logic                                   advance;
	logic [DATA_WIDTH-1:0]                  alu_value;
	wr_t                                    alu_wr;

	// The input stage moves on when the result slot is free or being taken.
	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.valid && instr.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (instr.valid && instr.ready) begin
			instr_s1.op       <= instr.op;
			instr_s1.dest_reg <= instr.dest_reg;
			instr_s1.src_a    <= instr.src_a;
			instr_s1.src_b    <= instr.src_b;
			instr_s1.imm      <= instr.imm;
		end
	end

	tra_alu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_alu (
		.instr(instr_s1),
		.a    (regs_q[instr_s1.src_a]),
		.b    (regs_q[instr_s1.src_b]),
		.value(alu_value),
		.wr   (alu_wr)
	);

	// Register file update; it also holds the pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (advance) begin
			for (int k = 0; k < NUM_REGS; k++) begin
				if ((alu_wr.dest_en && instr_s1.dest_reg == REG_IDX_W'(k)) ||
				    (alu_wr.src_en && instr_s1.src_a == REG_IDX_W'(k))) begin
					regs_q[k] <= alu_value;
				end
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.reg0_val = regs_q[0];
	assign result.reg1_val = regs_q[1];
	assign result.reg2_val = regs_q[2];
	assign result.reg3_val = regs_q[3];
	assign result.reg4_val = regs_q[4];
	assign result.reg5_val = regs_q[5];
	assign result.reg6_val = regs_q[6];
	assign result.reg7_val = regs_q[7];

	// An executed instruction always leaves a result behind.
	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("executed instruction did not produce a result");

	// The register file must not move while its result waits to be taken.
	a_stall_holds_regs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready && !advance) |=> $stable(regs_q))
		else $error("register file changed under a stalled result");

	// Backpressure on the input only comes from a full input stage behind a stalled result.
	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!instr.ready |-> (valid_s1 && out_valid_q && !result.ready))
		else $error("input stalled without a full pipeline");

	// A no-op leaves every register unchanged.
	a_nop_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && instr_s1.op == OP_NOP) |=> $stable(regs_q))
		else $error("no-op modified the register file");

endmodule

FILE: test/tb_toy_register_alu_executor.sv
`timescale 1ns / 1ps

module tb_toy_register_alu_executor;
	import tra_pkg::*;

	localparam int unsigned DW             = DATA_WIDTH_DEF;
	localparam logic [OP_W-1:0] OP_CODE_MAX = 4'hF;
	localparam int unsigned RANDOM_ITEMS   = 680;
	localparam int unsigned QUIET_ITEMS    = 120;
	localparam int unsigned HOLD_CYCLES    = 80;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef logic [NUM_REGS-1:0][DW-1:0] reg_snap_t;

	// Tracks the register file and the snapshots that the block still owes.
	class regfile_scoreboard;
		logic [DW-1:0] model_regs [NUM_REGS];
		reg_snap_t     snapshots_q [$];
		int unsigned   errors;

		function new();
			foreach (model_regs[k]) model_regs[k] = '0;
			errors = 0;
		endfunction

		// Executes one accepted instruction and queues the register file it leaves.
		function void note_instr(logic [OP_W-1:0] op, logic [REG_IDX_W-1:0] rd,
			logic [REG_IDX_W-1:0] ra, logic [REG_IDX_W-1:0] rb, logic [IMM_W-1:0] imm);
			logic [DW-1:0] a;
			logic [DW-1:0] b;
			logic [DW-1:0] shifted;
			reg_snap_t     snap;
			a = model_regs[ra];
			b = model_regs[rb];
			case (op)
				OP_ADD: model_regs[rd] = a + b;
				OP_AND: model_regs[rd] = a & b;
				OP_OR:  model_regs[rd] = a | b;
				OP_SUB: model_regs[rd] = a - b;
				OP_XOR: model_regs[rd] = a ^ b;
				OP_LSR: model_regs[rd] = (imm >= DW) ? '0 : a >> imm;
				OP_LSL: model_regs[rd] = (imm >= DW) ? '0 : a << imm;
				OP_ASR: begin
					// The shifted value goes back to the source and then to the destination.
					if (imm >= DW)
						shifted = {DW{a[DW-1]}};
					else
						shifted = $signed(a) >>> imm;
					model_regs[ra] = shifted;
					model_regs[rd] = shifted;
				end
				OP_MOV: model_regs[rd] = imm[DW-1:0];
				default: ;
			endcase
			foreach (model_regs[k]) snap[k] = model_regs[k];
			snapshots_q.push_back(snap);
		endfunction

		// Compares one accepted result with the oldest owed snapshot.
		function void check_regs(reg_snap_t actual);
			reg_snap_t want;
			int        k;
			if (snapshots_q.size() == 0) begin
				errors++;
				$display("%0t: result with no instruction outstanding, expected none, actual %h",
					$time, actual);
				return;
			end
			want = snapshots_q.pop_front();
			for (k = 0; k < NUM_REGS; k++) begin
				if (actual[k] !== want[k]) begin
					errors++;
					$display("%0t: reg%0d_val expected %h actual %h", $time, k, want[k], actual[k]);
				end
			end
		endfunction

		function int unsigned pending();
			return snapshots_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tra_instr_if             instr_bus ();
	tra_regs_if #(.DATA_WIDTH(DW)) regs_bus ();

	toy_register_alu_executor #(.DATA_WIDTH(DW)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_bus.sink),
		.result (regs_bus.source)
	);

	regfile_scoreboard board;
	reg_snap_t         seen_regs;
	int unsigned       stall_cycles;
	bit                hold_req;
	bit                ready_idle_en;

	// Free-running clock, 20 ns period.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result and request monitor; the result is checked before the new request is executed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (regs_bus.valid && regs_bus.ready) begin
				seen_regs = {regs_bus.reg7_val, regs_bus.reg6_val, regs_bus.reg5_val,
					regs_bus.reg4_val, regs_bus.reg3_val, regs_bus.reg2_val,
					regs_bus.reg1_val, regs_bus.reg0_val};
				board.check_regs(seen_regs);
			end
			if (instr_bus.valid && instr_bus.ready)
				board.note_instr(instr_bus.op, instr_bus.dest_reg, instr_bus.src_a,
					instr_bus.src_b, instr_bus.imm);
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	initial stall_cycles = 0;
	always @(posedge clk) begin
		if ((instr_bus.valid && instr_bus.ready) || (regs_bus.valid && regs_bus.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, stall_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off on request, and none at the end.
	initial begin
		regs_bus.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				regs_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (ready_idle_en && $urandom_range(0, 2) == 0) begin
				regs_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				regs_bus.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	function automatic logic [REG_IDX_W-1:0] any_reg();
		return REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
	endfunction

	// Offers one instruction and returns at the edge where it is accepted.
	task automatic send_instr(input logic [OP_W-1:0] op, input logic [REG_IDX_W-1:0] rd,
		input logic [REG_IDX_W-1:0] ra, input logic [REG_IDX_W-1:0] rb,
		input logic [IMM_W-1:0] imm);
		instr_bus.valid    <= 1'b1;
		instr_bus.op       <= op;
		instr_bus.dest_reg <= rd;
		instr_bus.src_a    <= ra;
		instr_bus.src_b    <= rb;
		instr_bus.imm      <= imm;
		@(posedge clk);
		while (!instr_bus.ready) @(posedge clk);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		instr_bus.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_results_drained();
		instr_bus.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	// Random instruction, mostly real operations, with shift amounts mostly in range.
	task automatic send_random();
		logic [OP_W-1:0]  op;
		logic [IMM_W-1:0] imm;
		int unsigned      pick;
		pick = $urandom_range(0, 99);
		if (pick < 2)
			op = OP_NOP;
		else if (pick < 5)
			op = OP_W'($urandom_range(OP_MOV + 1, OP_CODE_MAX));
		else
			op = OP_W'($urandom_range(OP_ADD, OP_MOV));
		pick = $urandom_range(0, 9);
		imm = $urandom;
		if (op == OP_LSR || op == OP_LSL || op == OP_ASR) begin
			if (pick < 7)
				imm = $urandom_range(0, DW - 1);
			else if (pick == 7)
				imm = DW;
		end else if (op == OP_MOV) begin
			if (pick == 0)
				imm = '0;
			else if (pick == 1)
				imm = '1;
		end
		send_instr(op, any_reg(), any_reg(), any_reg(), imm);
	endtask

	// Main stimulus.
	initial begin
		int  c;
		int  i;
		bit  idle_on;
		board              = new();
		hold_req           = 1'b0;
		ready_idle_en      = 1'b1;
		arst_n             = 1'b0;
		instr_bus.valid    = 1'b0;
		instr_bus.op       = OP_NOP;
		instr_bus.dest_reg = '0;
		instr_bus.src_a    = '0;
		instr_bus.src_b    = '0;
		instr_bus.imm      = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme values, every operation and the corner cases.
		send_instr(OP_MOV, 3'd0, any_reg(), any_reg(), 32'hFFFF_FFFF);
		send_instr(OP_MOV, 3'd1, any_reg(), any_reg(), 32'h0000_0001);
		send_instr(OP_MOV, 3'd7, any_reg(), any_reg(), 32'h8000_0000);
		send_instr(OP_ADD, 3'd2, 3'd0, 3'd1, $urandom);
		send_instr(OP_SUB, 3'd3, 3'd2, 3'd1, $urandom);
		send_instr(OP_AND, 3'd4, 3'd0, 3'd7, $urandom);
		send_instr(OP_OR, 3'd5, 3'd1, 3'd7, $urandom);
		send_instr(OP_XOR, 3'd6, 3'd0, 3'd7, $urandom);
		send_instr(OP_LSR, 3'd2, 3'd7, any_reg(), 32'd31);
		send_instr(OP_LSR, 3'd2, 3'd0, any_reg(), 32'd32);
		send_instr(OP_LSL, 3'd3, 3'd1, any_reg(), 32'd31);
		send_instr(OP_LSL, 3'd3, 3'd0, any_reg(), 32'hFFFF_FFFF);
		// Arithmetic shifts also rewrite their source register.
		send_instr(OP_ASR, 3'd4, 3'd7, any_reg(), 32'd4);
		send_instr(OP_ASR, 3'd5, 3'd7, any_reg(), 32'd40);
		send_instr(OP_ASR, 3'd6, 3'd6, any_reg(), 32'd0);
		send_instr(OP_ASR, 3'd1, 3'd1, any_reg(), 32'd100);
		send_instr(OP_NOP, any_reg(), any_reg(), any_reg(), $urandom);
		for (c = OP_MOV + 1; c <= OP_CODE_MAX; c++)
			send_instr(OP_W'(c), any_reg(), any_reg(), any_reg(), $urandom);
		send_instr(OP_MOV, 3'd7, any_reg(), any_reg(), 32'h0000_0000);
		wait_results_drained();

		// Random part with sender gaps, a long receiver hold-off and a full drain midway.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			idle_on = (i < RANDOM_ITEMS - QUIET_ITEMS) && ((i / 40) % 4 != 3);
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				ready_idle_en = 1'b0;
			if (i == 150)
				hold_req = 1'b1;
			if (i == 400)
				wait_results_drained();
			if (idle_on && $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 14));
			send_random();
		end

		// Let the last results come out, then watch for anything stray before the verdict.
		wait_results_drained();
		repeat (4) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/tra_pkg.sv
rtl/core/tra_instr_if.sv
rtl/core/tra_regs_if.sv
rtl/core/tra_alu.sv
rtl/core/toy_register_alu_executor.sv
test/tb_toy_register_alu_executor.sv
